// ----- hdl/pss_pkg.sv -----
`timescale 1ns / 1ps

package pss_pkg;

  // Sorting network geometry: sixteen lanes of eight-bit keys.
  localparam int LANES            = 16;
  localparam int KEY_W            = 8;
  localparam int BYTE_LANES       = 8;
  localparam int NIBBLE_W         = 4;
  localparam int WORD_W           = 64;
  localparam int STAGES           = 4;
  localparam int ROUNDS_PER_STAGE = 4;

  // Subword mode codes.
  localparam logic MODE_BYTE   = 1'b0;
  localparam logic MODE_NIBBLE = 1'b1;

  // Byte mode fills the unused upper lanes with the largest key.
  localparam logic [KEY_W-1:0]    PAD_KEY     = 8'hff;
  localparam logic [KEY_W-1:0]    BYTE_MASK   = 8'hff;
  localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hf;

  typedef logic [LANES-1:0][KEY_W-1:0] lane_vec_t;

  // Control that travels alongside each request through the pipeline.
  typedef struct packed {
    logic valid;
    logic mode;
  } pss_ctrl_t;

  // One round of odd-even transposition: compare-exchange on disjoint pairs.
  function automatic lane_vec_t cx_round(input lane_vec_t v, input logic odd);
    lane_vec_t r;
    r = v;
    for (int i = 0; i < LANES - 1; i++) begin
      if (i[0] == odd) begin
        if (v[i] > v[i+1]) begin
          r[i]   = v[i+1];
          r[i+1] = v[i];
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- hdl/pss_sort_stage.sv -----
`timescale 1ns / 1ps

module pss_sort_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  pss_pkg::pss_ctrl_t ctrl_in,
  input  pss_pkg::lane_vec_t lanes_in,
  output pss_pkg::pss_ctrl_t ctrl_out,
  output pss_pkg::lane_vec_t lanes_out
);
  import pss_pkg::*;

  pss_ctrl_t ctrl_r;
  lane_vec_t lanes_r;
  lane_vec_t lanes_nxt;

  // Four transposition rounds, alternating even and odd pairs.
  always_comb begin
    lanes_nxt = lanes_in;
    for (int k = 0; k < ROUNDS_PER_STAGE; k++) begin
      lanes_nxt = cx_round(lanes_nxt, k[0]);
    end
  end

  // Only the valid bit needs reset; the lanes are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
  end

  assign ctrl_out  = ctrl_r;
  assign lanes_out = lanes_r;

endmodule

// ----- hdl/packed_subword_sorter.sv -----
`timescale 1ns / 1ps

// Packed subword sorter.
// A request is presented on in_packed_word with start high; it is taken at any
// clock edge where busy is low, and busy is always low, so one request may be
// given every cycle. The word is sorted as eight bytes or sixteen nibbles,
// ascending, smallest value in the least significant position.
// The mode is written through cfg_wr_en / cfg_subword_mode (0 bytes,
// 1 nibbles) and is sampled into the pipeline with each request.
// The sorter is a sixteen-lane odd-even transposition network, four rounds per
// register stage over four stages, followed by an output register.
// The result appears on out_sorted_word with out_valid high for one cycle,
// after the four sort stage registers and the output register.
// Throughput: one word per cycle.
// The receiver has no way to stall the result; it must take it when out_valid
// is high. Reset clears the pipeline valid bits and sets byte mode.
module packed_subword_sorter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_packed_word,
  output logic        out_valid,
  output logic [63:0] out_sorted_word,
  input  logic        cfg_wr_en,
  input  logic        cfg_subword_mode
);
  import pss_pkg::*;

  logic                 mode_r;
  pss_ctrl_t            head_ctrl;
  lane_vec_t            head_lanes;
  pss_ctrl_t            ctrl_s  [0:STAGES];
  lane_vec_t            lanes_s [0:STAGES];
  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_word_r;
  logic [WORD_W-1:0]    out_word_nxt;

  assign busy = 1'b0;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BYTE;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_subword_mode;
    end
  end

  // Split the word into lanes; byte mode pads the upper lanes with the top key.
  always_comb begin
    head_ctrl.valid = start && !busy;
    head_ctrl.mode  = mode_r;
    for (int i = 0; i < LANES; i++) begin
      if (mode_r == MODE_NIBBLE) begin
        head_lanes[i] = {{(KEY_W-NIBBLE_W){1'b0}},
                         in_packed_word[NIBBLE_W*i +: NIBBLE_W] & NIBBLE_MASK};
      end else if (i < BYTE_LANES) begin
        head_lanes[i] = in_packed_word[KEY_W*i +: KEY_W] & BYTE_MASK;
      end else begin
        head_lanes[i] = PAD_KEY;
      end
    end
  end

  assign ctrl_s[0]  = head_ctrl;
  assign lanes_s[0] = head_lanes;

  // Chain of sorting stages.
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    pss_sort_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl_in  (ctrl_s[s]),
      .lanes_in (lanes_s[s]),
      .ctrl_out (ctrl_s[s+1]),
      .lanes_out(lanes_s[s+1])
    );
  end

  // Pack the sorted lanes back into a word.
  always_comb begin
    out_word_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      if (ctrl_s[STAGES].mode == MODE_NIBBLE) begin
        out_word_nxt[NIBBLE_W*i +: NIBBLE_W] = lanes_s[STAGES][i][NIBBLE_W-1:0];
      end else if (i < BYTE_LANES) begin
        out_word_nxt[KEY_W*i +: KEY_W] = lanes_s[STAGES][i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl_s[STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sorted_word = out_word_r;

endmodule

// ----- verif/tb_packed_subword_sorter.sv -----
`timescale 1ns / 1ps

module tb_packed_subword_sorter;
  import pss_pkg::*;

  localparam int IDLE_LIMIT = 500;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX = 10;

  // Kinds of random words, chosen to reach duplicates and presorted orders.
  typedef enum int {
    WORD_RANDOM,
    WORD_FEW_VALUES,
    WORD_ASCENDING,
    WORD_DESCENDING
  } word_kind_e;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_packed_word;
  logic        out_valid;
  logic [63:0] out_sorted_word;
  logic        cfg_wr_en;
  logic        cfg_subword_mode;

  logic        cur_mode;
  logic [63:0] pending_sorted[$];
  int          error_count;
  int          burst_left;
  int          idle_cycles;

  packed_subword_sorter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_packed_word   (in_packed_word),
    .out_valid        (out_valid),
    .out_sorted_word  (out_sorted_word),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_subword_mode (cfg_subword_mode)
  );

  // Free-running clock, 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Expected sorted word: tally each subword value, then lay the values out
  // from the least significant position upward.
  function automatic logic [63:0] sort_packed(input logic [63:0] w, input logic mode);
    int unsigned tally[256];
    int width;
    int lanes;
    int pos;
    logic [63:0] mask;
    logic [63:0] r;
    width = (mode == MODE_NIBBLE) ? NIBBLE_W : KEY_W;
    lanes = WORD_W / width;
    mask = (mode == MODE_NIBBLE) ? 64'(NIBBLE_MASK) : 64'(BYTE_MASK);
    foreach (tally[k]) tally[k] = 0;
    for (int i = 0; i < lanes; i++) begin
      tally[int'((w >> (i * width)) & mask)]++;
    end
    r = '0;
    pos = 0;
    for (int k = 0; k < 256; k++) begin
      for (int n = 0; n < int'(tally[k]); n++) begin
        r = r | (64'(k) << (pos * width));
        pos++;
      end
    end
    return r;
  endfunction

  // Build one random word of the given kind for the current subword width.
  function automatic logic [63:0] make_word(input word_kind_e kind, input logic mode);
    logic [63:0] w;
    logic [63:0] flipped;
    logic [7:0] pool[3];
    int width;
    int lanes;
    w = {$urandom, $urandom};
    width = (mode == MODE_NIBBLE) ? NIBBLE_W : KEY_W;
    lanes = WORD_W / width;
    case (kind)
      WORD_FEW_VALUES: begin
        foreach (pool[k]) pool[k] = 8'($urandom);
        w = '0;
        for (int i = 0; i < lanes; i++) begin
          w = w | ((64'(pool[$urandom_range(0, 2)]) & ((64'd1 << width) - 1)) << (i * width));
        end
      end
      WORD_ASCENDING: begin
        w = sort_packed(w, mode);
      end
      WORD_DESCENDING: begin
        w = sort_packed(w, mode);
        flipped = '0;
        for (int i = 0; i < lanes; i++) begin
          flipped = flipped | (((w >> (i * width)) & ((64'd1 << width) - 1))
                               << ((lanes - 1 - i) * width));
        end
        w = flipped;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Present one request and hold it until it is taken; then maybe pause.
  task automatic send_word(input logic [63:0] w);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    in_packed_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_sorted.push_back(sort_packed(w, cur_mode));
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Change the subword mode once every outstanding result has come back.
  task automatic set_mode(input logic mode);
    @(negedge clk);
    start <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_subword_mode <= mode;
    @(posedge clk);
    cur_mode = mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Byte mode: extremes, sorted and reversed orders, duplicates.
  task automatic test_directed_bytes();
    set_mode(MODE_BYTE);
    send_word(64'h0000_0000_0000_0000);
    send_word(64'hffff_ffff_ffff_ffff);
    send_word(64'h0706_0504_0302_0100);
    send_word(64'h0001_0203_0405_0607);
    send_word(64'h00ff_00ff_00ff_00ff);
    send_word(64'h0000_0000_0000_00ff);
    send_word(64'h0505_0505_0505_0505);
    send_word(64'h8001_7f80_01fe_ff00);
  endtask

  // Nibble mode: same shapes across sixteen lanes.
  task automatic test_directed_nibbles();
    set_mode(MODE_NIBBLE);
    send_word(64'h0000_0000_0000_0000);
    send_word(64'hffff_ffff_ffff_ffff);
    send_word(64'hfedc_ba98_7654_3210);
    send_word(64'h0123_4567_89ab_cdef);
    send_word(64'hf0f0_f0f0_f0f0_f0f0);
    send_word(64'h0000_0000_0000_000f);
    send_word(64'h1111_1111_2111_1111);
    send_word(64'h8f70_1e69_a5c3_b4d2);
  endtask

  // Random words in one mode, half plain random and the rest shaped ones.
  task automatic test_random(input logic mode, input int count);
    word_kind_e kind;
    int pick;
    set_mode(mode);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      kind = pick < 5 ? WORD_RANDOM : pick < 7 ? WORD_FEW_VALUES :
             pick < 8 ? WORD_ASCENDING : WORD_DESCENDING;
      send_word(make_word(kind, cur_mode));
    end
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_sorted.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result %h", out_sorted_word);
      end else begin
        if (out_sorted_word !== pending_sorted[0]) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("sorted word mismatch: expected %h, got %h",
                     pending_sorted[0], out_sorted_word);
        end
        void'(pending_sorted.pop_front());
      end
    end
  end

  // Stop the run if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_packed_word = '0;
    cfg_wr_en = 1'b0;
    cfg_subword_mode = MODE_BYTE;
    cur_mode = MODE_BYTE;
    error_count = 0;
    burst_left = 1;
    idle_cycles = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_bytes();
    test_directed_nibbles();
    test_random(MODE_BYTE, 140);
    test_random(MODE_NIBBLE, 140);
    test_random(MODE_BYTE, 130);
    test_random(MODE_NIBBLE, 140);

    // Drain the pipeline and watch for stray results.
    @(negedge clk);
    start <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_sorted.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
